>>> design/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared widths, status codes, sequencer states and divider interface types
// for the gcd/lcm unit.
// ----------------------------------------------------------------------------
package gcl_pkg;

    localparam int IN_W      = 64;
    localparam int MAG_W     = 20;
    localparam int MUL_W     = 40;
    localparam int ST_W      = 2;
    localparam int DIV_CNT_W = $clog2(MAG_W);

    localparam logic [IN_W-1:0] MAG_LIMIT = 64'd1000000;
    localparam logic [IN_W-1:0] MOST_NEG  = 64'h8000_0000_0000_0000;

    localparam logic [ST_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [ST_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [ST_W-1:0] STATUS_RANGE    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_LCM,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [MAG_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
        logic [MAG_W-1:0] remainder;
    } t_div_rsp;

endpackage

>>> design/gcl_div.sv
// ----------------------------------------------------------------------------
// gcl_div
// Restoring radix-2 divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses with quotient and remainder after the last bit.
// ----------------------------------------------------------------------------
module gcl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gcl_pkg::t_div_req i_req,
    output gcl_pkg::t_div_rsp o_rsp
);
    import gcl_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0]     r_rem;
    logic [MAG_W-1:0]     r_quo;
    logic [MAG_W-1:0]     r_div;

    logic [MAG_W:0]       w_trial;
    logic [MAG_W:0]       w_diff;
    logic                 w_last;

    assign w_trial = {r_rem, r_quo[MAG_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_last  = (r_cnt == DIV_CNT_W'(MAG_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into the dividend register from the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[MAG_W]) begin
                r_rem <= w_diff[MAG_W-1:0];
                r_quo <= {r_quo[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[MAG_W-1:0];
                r_quo <= {r_quo[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

>>> design/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor and least common multiple of two signed operands.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry i_first_value and i_second_value.
// Output channel: o_valid / i_ready carry o_divisor_result,
// o_multiple_result and o_status (0 ok, 1 most negative operand,
// 2 magnitude above one million).
// One item at a time: o_ready is high only while the unit is idle.
// All divisions run on one shared bit-serial divider.
// Euclid takes k remainder steps (k <= 29 for magnitudes up to one million),
// then one more division for |a|/g and a multiply of that quotient by |b|.
// Error items and items with a zero second operand skip the divider and
// present a result the cycle after accept.
// The result is held in registers until i_ready; a stalled receiver keeps
// the unit busy and no new item is taken.
// Reset returns the sequencer to idle; nothing else is kept between items.
// ----------------------------------------------------------------------------
module gcd_lcm_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [gcl_pkg::IN_W-1:0]     i_first_value,
    input  logic signed [gcl_pkg::IN_W-1:0]     i_second_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic        [gcl_pkg::MAG_W-1:0]    o_divisor_result,
    output logic        [gcl_pkg::MUL_W-1:0]    o_multiple_result,
    output logic        [gcl_pkg::ST_W-1:0]     o_status
);
    import gcl_pkg::*;

    t_state           r_state;
    t_state           n_state;

    logic [MAG_W-1:0] r_ma;
    logic [MAG_W-1:0] r_mb;
    logic [MAG_W-1:0] r_y;
    logic [MAG_W-1:0] r_q;
    logic [MAG_W-1:0] r_g;
    logic [MUL_W-1:0] r_l;
    logic [ST_W-1:0]  r_st;

    logic [IN_W-1:0]  w_raw_a;
    logic [IN_W-1:0]  w_raw_b;
    logic [IN_W-1:0]  w_mag_a;
    logic [IN_W-1:0]  w_mag_b;
    logic             w_ovf;
    logic             w_rng;
    logic             w_early;

    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;

    gcl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_raw_a = $unsigned(i_first_value);
    assign w_raw_b = $unsigned(i_second_value);
    assign w_mag_a = w_raw_a[IN_W-1] ? (~w_raw_a + 64'd1) : w_raw_a;
    assign w_mag_b = w_raw_b[IN_W-1] ? (~w_raw_b + 64'd1) : w_raw_b;
    assign w_ovf   = (w_raw_a == MOST_NEG) || (w_raw_b == MOST_NEG);
    assign w_rng   = (w_mag_a > MAG_LIMIT) || (w_mag_b > MAG_LIMIT);
    // zero second operand: gcd is |a|, lcm is zero, no division needed
    assign w_early = w_ovf || w_rng || (w_mag_b == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = w_early ? S_OUT : S_GCD;
                end
            end
            S_GCD: begin
                if (w_div_rsp.done && (w_div_rsp.remainder == '0)) begin
                    n_state = S_LCM;
                end
            end
            S_LCM: begin
                if (w_div_rsp.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready            = 1'b0;
        o_valid            = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_mag_a[MAG_W-1:0];
        w_div_req.divisor  = w_mag_b[MAG_W-1:0];
        case (r_state)
            S_IDLE: begin
                o_ready         = 1'b1;
                w_div_req.start = i_valid && !w_early;
            end
            S_GCD: begin
                if (w_div_rsp.done) begin
                    w_div_req.start = 1'b1;
                    if (w_div_rsp.remainder != '0) begin
                        w_div_req.dividend = r_y;
                        w_div_req.divisor  = w_div_rsp.remainder;
                    end else begin
                        // gcd found in r_y: next division is |a| / g
                        w_div_req.dividend = r_ma;
                        w_div_req.divisor  = r_y;
                    end
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_ma <= w_mag_a[MAG_W-1:0];
                    r_mb <= w_mag_b[MAG_W-1:0];
                    r_y  <= w_mag_b[MAG_W-1:0];
                    r_l  <= '0;
                    if (w_ovf) begin
                        r_st <= STATUS_OVERFLOW;
                        r_g  <= '0;
                    end else if (w_rng) begin
                        r_st <= STATUS_RANGE;
                        r_g  <= '0;
                    end else begin
                        r_st <= STATUS_OK;
                        r_g  <= w_mag_a[MAG_W-1:0];
                    end
                end
            end
            S_GCD: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.remainder != '0) begin
                        r_y <= w_div_rsp.remainder;
                    end else begin
                        r_g <= r_y;
                    end
                end
            end
            S_LCM: begin
                if (w_div_rsp.done) begin
                    r_q <= w_div_rsp.quotient;
                end
            end
            S_MUL: begin
                r_l <= MUL_W'(r_q) * MUL_W'(r_mb);
            end
            default: begin
            end
        endcase
    end

    assign o_divisor_result  = r_g;
    assign o_multiple_result = r_l;
    assign o_status          = r_st;

`ifndef SYNTH
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input accepted while a result is pending");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STATUS_OK))
            |-> (o_divisor_result == '0) && (o_multiple_result == '0))
        else $error("error item carries nonzero results");

    a_div_done_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_GCD) || (r_state == S_LCM))
        else $error("divider finished outside a division state");

    a_lcm_needs_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_multiple_result != '0)) |-> (o_divisor_result != '0))
        else $error("nonzero lcm with zero gcd");
`endif

endmodule
